### rtl/core/bswr_pkg.sv
// Shared constants, types and helpers for the binned sliding-window rate core.
package bswr_pkg;

   localparam int NUM_BINS = 8;                        // power of two
   localparam int IDX_W    = $clog2(NUM_BINS);
   localparam int CNT_W    = $clog2(NUM_BINS + 1);
   localparam int WIN_W    = 27;
   localparam int BWID_W   = WIN_W - IDX_W;            // bin width bits
   localparam int TIME_W   = 32;
   localparam int EVT_W    = 16;
   localparam int NORM_W   = 31;
   localparam int DIV_W    = 64;                       // dividend width
   localparam int DIVS_W   = 32;                       // divisor width
   localparam int PROD_W   = TIME_W + WIN_W;
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000);

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_RESTART, OP_PREP, OP_DIV_K, OP_K_CAP, OP_K_MUL,
      OP_FILL_SETUP, OP_FILL, OP_ADVANCE, OP_ADD, OP_SCAN_INIT, OP_SCAN,
      OP_SUM, OP_NORM_MUL, OP_DIV_N, OP_FINISH
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_RESTART, S_PREP, S_GAP, S_DIVK, S_KCAP, S_KMUL,
      S_FSET, S_FILL, S_ADV, S_ADD, S_SCAN0, S_SCAN, S_SUM, S_MUL,
      S_DIVN_GO, S_DIVN, S_FIN
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic restart;     // first word or time went backwards
      logic long_gap;    // time since the current bin start exceeds one bin width
      logic div_done;
      logic fill_done;
      logic advanced;
      logic scan_last;
      logic cov_zero;
      logic out_busy;
   } status_type;

   function automatic logic [TIME_W-1:0] sat_add32(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

### rtl/core/bswr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module bswr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bswr_pkg::DIV_W-1:0]  dividend,
   input  logic [bswr_pkg::DIVS_W-1:0] divisor,
   output logic [bswr_pkg::DIV_W-1:0]  quotient,
   output logic                        done
);
   localparam int STEP_W = $clog2(bswr_pkg::DIV_W + 1);

   logic [bswr_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [bswr_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [bswr_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]           cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [bswr_pkg::DIVS_W:0]   shifted, trial;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[bswr_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = STEP_W'(bswr_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[bswr_pkg::DIVS_W]) begin
            rem_in = trial[bswr_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[bswr_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[bswr_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[bswr_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

### rtl/core/bswr_datapath.sv
// Bin ring, sums, multiply and shared divider, stepped by controller commands.
module bswr_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bswr_pkg::cmd_type            cmd,
   output bswr_pkg::status_type         status,
   input  logic [63:0]                  req_tdata,
   input  logic                         csr_we,
   input  logic [bswr_pkg::WIN_W-1:0]   csr_wdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [95:0]                  rsp_tdata,
   output logic                         rsp_tuser
);
   localparam int TW = bswr_pkg::TIME_W;
   localparam int IW = bswr_pkg::IDX_W;
   localparam int CW = bswr_pkg::CNT_W;

   // state
   logic [bswr_pkg::WIN_W-1:0] win_ff;
   logic [TW-1:0]   counts_ff [bswr_pkg::NUM_BINS];
   logic [TW-1:0]   starts_ff [bswr_pkg::NUM_BINS];
   logic [bswr_pkg::NUM_BINS-1:0] valid_ff;
   logic [IW-1:0]   cur_ff;
   logic [TW-1:0]   prev_ff;
   logic            started_ff;
   logic [TW-1:0]   oc_ff, ot_ff;
   logic [bswr_pkg::NORM_W-1:0] last_norm_ff;
   logic [TW-1:0]   last_raw_ff, last_cov_ff;
   // per-word working registers
   logic [TW-1:0]   t_ff, dt_ff, st_ff, k_ff, kw_ff, s_ff, raw_ff, cov_ff;
   logic [bswr_pkg::EVT_W:0] delta_ff;
   logic [bswr_pkg::BWID_W-1:0] width_ff;
   logic [IW-1:0]   widx_ff;
   logic [CW-1:0]   mcnt_ff, sidx_ff;
   logic            adv_ff;
   logic [TW-1:0]   pstart_ff, pcount_ff;
   logic            pvalid_ff;
   logic [bswr_pkg::PROD_W-1:0] prod_ff;
   // output register
   logic            rsp_valid_ff;
   logic [95:0]     rsp_data_ff;
   logic            rsp_user_ff;

   // divider hookup
   logic                        div_start;
   logic [bswr_pkg::DIV_W-1:0]  div_dividend, div_quo;
   logic [bswr_pkg::DIVS_W-1:0] div_divisor;
   logic                        div_done;

   // single bin read port
   logic [IW-1:0]   rd_idx;
   logic [TW-1:0]   rd_count, rd_start;
   logic            rd_valid;
   logic [bswr_pkg::BWID_W-1:0] width_raw;
   logic [bswr_pkg::DIV_W-1:0]  q_sel;
   logic            load_out;

   function automatic logic [bswr_pkg::NORM_W-1:0] rsp_data_ff_next_norm(
         input logic [bswr_pkg::DIV_W-1:0] q);
      return (q > {{(bswr_pkg::DIV_W-bswr_pkg::NORM_W){1'b0}}, {bswr_pkg::NORM_W{1'b1}}}) ?
             {bswr_pkg::NORM_W{1'b1}} : q[bswr_pkg::NORM_W-1:0];
   endfunction

   always_comb begin
      case (cmd.op)
         bswr_pkg::OP_SCAN_INIT: rd_idx = '0;
         bswr_pkg::OP_SCAN:      rd_idx = sidx_ff[IW-1:0];
         default:                rd_idx = cur_ff;
      endcase
   end
   assign rd_count = counts_ff[rd_idx];
   assign rd_start = starts_ff[rd_idx];
   assign rd_valid = valid_ff[rd_idx];

   assign width_raw = win_ff[bswr_pkg::WIN_W-1:IW];

   assign div_start    = (cmd.op == bswr_pkg::OP_DIV_K) || (cmd.op == bswr_pkg::OP_DIV_N);
   assign div_dividend = (cmd.op == bswr_pkg::OP_DIV_K) ?
                         {{(bswr_pkg::DIV_W-TW){1'b0}}, dt_ff - TW'(1)} :
                         {{(bswr_pkg::DIV_W-bswr_pkg::PROD_W){1'b0}}, prod_ff};
   assign div_divisor  = (cmd.op == bswr_pkg::OP_DIV_K) ?
                         {{(bswr_pkg::DIVS_W-bswr_pkg::BWID_W){1'b0}}, width_ff} : cov_ff;

   bswr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign q_sel = (cov_ff == '0) ?
                  {{(bswr_pkg::DIV_W-bswr_pkg::PROD_W){1'b0}}, prod_ff} : div_quo;

   assign load_out = (cmd.op == bswr_pkg::OP_RESTART) || (cmd.op == bswr_pkg::OP_FINISH);

   // status back to the controller
   assign status.restart   = !started_ff || (t_ff < prev_ff);
   assign status.long_gap  = dt_ff > {{(TW-bswr_pkg::BWID_W){1'b0}}, width_ff};
   assign status.div_done  = div_done;
   assign status.fill_done = (mcnt_ff == '0);
   assign status.advanced  = adv_ff;
   assign status.scan_last = (sidx_ff == CW'(bswr_pkg::NUM_BINS));
   assign status.cov_zero  = (cov_ff == '0);
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   // control-state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= bswr_pkg::WIN_RESET;
         valid_ff     <= '0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         started_ff   <= 1'b0;
         oc_ff        <= '0;
         ot_ff        <= '0;
         last_norm_ff <= '0;
         last_raw_ff  <= '0;
         last_cov_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) win_ff <= csr_wdata;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            bswr_pkg::OP_RESTART: begin
               valid_ff   <= {{(bswr_pkg::NUM_BINS-1){1'b0}}, 1'b1};
               cur_ff     <= '0;
               prev_ff    <= t_ff;
               started_ff <= 1'b1;
               oc_ff      <= '0;
               ot_ff      <= '0;
            end
            bswr_pkg::OP_PREP:    prev_ff <= t_ff;
            bswr_pkg::OP_FILL:    valid_ff[widx_ff] <= 1'b1;
            bswr_pkg::OP_ADVANCE: cur_ff <= cur_ff + k_ff[IW-1:0];
            bswr_pkg::OP_SCAN_INIT: begin
               oc_ff <= '0;
               ot_ff <= '0;
            end
            bswr_pkg::OP_SCAN: begin
               // pair (sidx-1, sidx) counts when sidx-1 is not the current bin, both are valid and time moves up
               if ((sidx_ff - CW'(1)) != {{(CW-IW){1'b0}}, cur_ff} && pvalid_ff &&
                   rd_valid && (rd_start > pstart_ff)) begin
                  oc_ff <= bswr_pkg::sat_add32(oc_ff, pcount_ff);
                  ot_ff <= bswr_pkg::sat_add32(ot_ff, rd_start - pstart_ff);
               end
            end
            bswr_pkg::OP_FINISH: begin
               last_norm_ff <= rsp_data_ff_next_norm(q_sel);
               last_raw_ff  <= raw_ff;
               last_cov_ff  <= cov_ff;
            end
            default: ;
         endcase
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         bswr_pkg::OP_LOAD: begin
            t_ff     <= req_tdata[31:0];
            delta_ff <= {1'b0, req_tdata[47:32]} + {1'b0, req_tdata[63:48]};
         end
         bswr_pkg::OP_RESTART: begin
            counts_ff[0] <= '0;
            starts_ff[0] <= t_ff;
            rsp_data_ff  <= {1'b0, last_cov_ff, last_raw_ff, last_norm_ff};
            rsp_user_ff  <= 1'b1;
         end
         bswr_pkg::OP_PREP: begin
            width_ff <= (width_raw == '0) ? bswr_pkg::BWID_W'(1) : width_raw;
            st_ff    <= rd_start;
            dt_ff    <= t_ff - rd_start;
            adv_ff   <= 1'b0;
         end
         bswr_pkg::OP_K_CAP: k_ff  <= div_quo[TW-1:0];
         bswr_pkg::OP_K_MUL: kw_ff <= TW'(k_ff * width_ff);
         bswr_pkg::OP_FILL_SETUP: begin
            s_ff    <= st_ff + kw_ff;
            widx_ff <= cur_ff + k_ff[IW-1:0];
            mcnt_ff <= (k_ff >= TW'(bswr_pkg::NUM_BINS)) ? CW'(bswr_pkg::NUM_BINS)
                                                         : k_ff[CW-1:0];
            adv_ff  <= 1'b1;
         end
         bswr_pkg::OP_FILL: begin
            // walk backwards from the newest bin entered
            counts_ff[widx_ff] <= '0;
            starts_ff[widx_ff] <= s_ff;
            s_ff    <= s_ff - {{(TW-bswr_pkg::BWID_W){1'b0}}, width_ff};
            widx_ff <= widx_ff - IW'(1);
            mcnt_ff <= mcnt_ff - CW'(1);
         end
         bswr_pkg::OP_ADD:
            counts_ff[cur_ff] <= bswr_pkg::sat_add32(rd_count,
                                 {{(TW-bswr_pkg::EVT_W-1){1'b0}}, delta_ff});
         bswr_pkg::OP_SCAN_INIT: begin
            pstart_ff <= rd_start;
            pcount_ff <= rd_count;
            pvalid_ff <= rd_valid;
            sidx_ff   <= CW'(1);
         end
         bswr_pkg::OP_SCAN: begin
            pstart_ff <= rd_start;
            pcount_ff <= rd_count;
            pvalid_ff <= rd_valid;
            sidx_ff   <= sidx_ff + CW'(1);
         end
         bswr_pkg::OP_SUM: begin
            raw_ff <= bswr_pkg::sat_add32(oc_ff, rd_count);
            cov_ff <= bswr_pkg::sat_add32(ot_ff, t_ff - rd_start);
         end
         bswr_pkg::OP_NORM_MUL: prod_ff <= raw_ff * win_ff;
         bswr_pkg::OP_FINISH: begin
            rsp_data_ff <= {1'b0, cov_ff, raw_ff, rsp_data_ff_next_norm(q_sel)};
            rsp_user_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

### rtl/core/bswr_ctrl.sv
// Sequencer that steps the datapath through one word.
module bswr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bswr_pkg::status_type  status,
   output bswr_pkg::cmd_type     cmd
);
   bswr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bswr_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   // next state and command
   always_comb begin
      state_in   = state_ff;
      cmd.op     = bswr_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         bswr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = bswr_pkg::OP_LOAD;
               state_in = bswr_pkg::S_CHECK;
            end
         end
         bswr_pkg::S_CHECK:
            state_in = status.restart ? bswr_pkg::S_RESTART : bswr_pkg::S_PREP;
         bswr_pkg::S_RESTART:
            if (!status.out_busy) begin
               cmd.op   = bswr_pkg::OP_RESTART;
               state_in = bswr_pkg::S_IDLE;
            end
         bswr_pkg::S_PREP: begin
            cmd.op   = bswr_pkg::OP_PREP;
            state_in = bswr_pkg::S_GAP;
         end
         bswr_pkg::S_GAP:
            if (status.long_gap) begin
               cmd.op   = bswr_pkg::OP_DIV_K;
               state_in = bswr_pkg::S_DIVK;
            end else begin
               state_in = bswr_pkg::S_ADD;
            end
         bswr_pkg::S_DIVK:
            if (status.div_done) state_in = bswr_pkg::S_KCAP;
         bswr_pkg::S_KCAP: begin
            cmd.op   = bswr_pkg::OP_K_CAP;
            state_in = bswr_pkg::S_KMUL;
         end
         bswr_pkg::S_KMUL: begin
            cmd.op   = bswr_pkg::OP_K_MUL;
            state_in = bswr_pkg::S_FSET;
         end
         bswr_pkg::S_FSET: begin
            cmd.op   = bswr_pkg::OP_FILL_SETUP;
            state_in = bswr_pkg::S_FILL;
         end
         bswr_pkg::S_FILL:
            if (status.fill_done) state_in = bswr_pkg::S_ADV;
            else cmd.op = bswr_pkg::OP_FILL;
         bswr_pkg::S_ADV: begin
            cmd.op   = bswr_pkg::OP_ADVANCE;
            state_in = bswr_pkg::S_ADD;
         end
         bswr_pkg::S_ADD: begin
            cmd.op   = bswr_pkg::OP_ADD;
            state_in = status.advanced ? bswr_pkg::S_SCAN0 : bswr_pkg::S_SUM;
         end
         bswr_pkg::S_SCAN0: begin
            cmd.op   = bswr_pkg::OP_SCAN_INIT;
            state_in = bswr_pkg::S_SCAN;
         end
         bswr_pkg::S_SCAN: begin
            cmd.op = bswr_pkg::OP_SCAN;
            if (status.scan_last) state_in = bswr_pkg::S_SUM;
         end
         bswr_pkg::S_SUM: begin
            cmd.op   = bswr_pkg::OP_SUM;
            state_in = bswr_pkg::S_MUL;
         end
         bswr_pkg::S_MUL: begin
            cmd.op   = bswr_pkg::OP_NORM_MUL;
            state_in = status.cov_zero ? bswr_pkg::S_FIN : bswr_pkg::S_DIVN_GO;
         end
         bswr_pkg::S_DIVN_GO: begin
            cmd.op   = bswr_pkg::OP_DIV_N;
            state_in = bswr_pkg::S_DIVN;
         end
         bswr_pkg::S_DIVN:
            if (status.div_done) state_in = bswr_pkg::S_FIN;
         bswr_pkg::S_FIN:
            if (!status.out_busy) begin
               cmd.op   = bswr_pkg::OP_FINISH;
               state_in = bswr_pkg::S_IDLE;
            end
         default: state_in = bswr_pkg::S_IDLE;
      endcase
   end
endmodule

### rtl/core/binned_sliding_window_rate_core.sv
// Top level of the binned sliding-window event rate core.
//
//   channel | dir | handshake                | payload
//   req     | in  | req_tvalid / req_tready  | tdata: time_ms, rising_delta, falling_delta
//   rsp     | out | rsp_tvalid / rsp_tready  | tdata: normalized_count, raw_count,
//           |     |                          |        covered_ms; tuser: restarted
//   csr     | in  | csr_we                   | csr_wdata: window_ms
//
// A word within one bin width runs the 64-step shared divider once to scale the count
// (not when no time is covered); a word that crosses bins adds a second 64-step divide
// for the bin advance, a fill of up to NUM_BINS new bins and a scan of the ring.
// Synchronous reset clears the ring valid bits and the control state at once and loads
// the window with WIN_RESET. The result sits in an output register; the next word is
// taken while it waits, and the core stalls only if a second result is ready before
// the first is taken.
module binned_sliding_window_rate_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [31:0] time_ms, [47:32] rising_delta,
                                     // [63:48] falling_delta
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,    // [30:0] normalized_count, [62:31] raw_count,
                                     // [94:63] covered_ms, [95] zero
   output logic        rsp_tuser,    // restarted
   input  logic        csr_we,
   input  logic [26:0] csr_wdata     // window_ms
);
   bswr_pkg::cmd_type    cmd;
   bswr_pkg::status_type status;

   bswr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bswr_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
